[src/bdq_pkg.sv]
// Shared constants for the bounded deque: command and status codes, field widths.
package bdq_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  // value reported at both ends of an empty deque
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

endpackage

[src/bdq_ram.sv]
// Element store: one write port, two registered read ports.
module bdq_ram import bdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic signed [DATA_W-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr_a,
  input  logic [$clog2(DEPTH)-1:0]         raddr_b,
  output logic signed [DATA_W-1:0]         rdata_a,
  output logic signed [DATA_W-1:0]         rdata_b
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  // read-before-write; the caller forwards same-entry writes
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[src/bounded_deque_top.sv]
// Bounded double-ended queue top level: command decode, ring pointers, result staging.
//
// A bounded deque of signed 32-bit values held in a ring of DEPTH entries,
// located by a head pointer and an element count. A command beat is taken on
// any clock edge where start is high; busy never rises, so one command can be
// issued every cycle. Each command gives exactly one result beat, on
// out_strobe, in the cycle right after the command was taken; the result
// ports hold for that one cycle only and the receiver must capture them then.
// Results are registered, taken from the registered read ports of the element
// store: the accept cycle updates head and count, writes a pushed element and
// reads both new ends in the same cycle, forwarding the pushed value when a
// read hits the entry being written. A push when the count has reached
// min(capacity, DEPTH) reports overflow and changes nothing; a pop on an
// empty deque reports underflow. An empty deque reads 2147483647 at both
// ends. Unknown command codes act as queries. The capacity register is
// written through the cfg_ channel, which is always ready; write it only
// while no result is pending. Lowering capacity below the current count
// keeps all elements; pushes then overflow until pops make room.
module bounded_deque_top import bdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [CMD_W-1:0]                  in_cmd,
  input  logic signed [DATA_W-1:0]          in_value,
  // result channel
  output logic                              out_strobe,
  output logic [STAT_W-1:0]                 out_status,
  output logic [$clog2(DEPTH+1)-1:0]        out_count,
  output logic signed [DATA_W-1:0]          out_front_value,
  output logic signed [DATA_W-1:0]          out_rear_value,
  // capacity register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CAP_W-1:0]                  cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;                  // head + count without overflow
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  // ring add: head + off, with off <= DEPTH, so one subtract wraps it
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] h,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // ---------------------------------------------------------------- state
  logic [CAP_W-1:0]          cap_r;
  logic [AW-1:0]             head_r, head_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      strobe_r;
  logic [STAT_W-1:0]         status_r, status_nxt;
  logic                      fwd_front_r, fwd_rear_r;
  logic signed [DATA_W-1:0]  wdata_r;

  logic                      acc;
  logic                      full, empty;
  logic [LW-1:0]             limit;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             front_addr, rear_addr;
  logic [CW-1:0]             rear_off;
  logic signed [DATA_W-1:0]  rd_front, rd_rear;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // ------------------------------------------------------- command decode
  // effective limit is the smaller of capacity and the ring depth
  assign limit = (LW'(cap_r) < LW'(DEPTH)) ? LW'(cap_r) : LW'(DEPTH);
  assign full  = LW'(cnt_r) >= limit;
  assign empty = (cnt_r == '0);

  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    status_nxt = ST_DONE;
    we         = 1'b0;
    waddr      = ring_add(head_r, cnt_r);  // slot behind the rear
    case (in_cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          head_nxt = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
          waddr    = head_nxt;
          we       = 1'b1;
          cnt_nxt  = cnt_r + CW'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          we      = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
          cnt_nxt  = cnt_r - CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      CMD_QUERY: begin
      end
      default: begin
        // unknown codes behave as a query
      end
    endcase
  end

  // ends of the deque after this command
  assign rear_off   = (cnt_nxt == '0) ? '0 : cnt_nxt - CW'(1);
  assign front_addr = head_nxt;
  assign rear_addr  = ring_add(head_nxt, rear_off);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= acc;
      if (acc) begin
        head_r <= head_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  // result payload and forwarding flags; no reset needed
  always_ff @(posedge clk) begin
    if (acc) begin
      status_r    <= status_nxt;
      wdata_r     <= in_value;
      fwd_front_r <= we && (waddr == front_addr);
      fwd_rear_r  <= we && (waddr == rear_addr);
    end
  end

  bdq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (acc && we),
    .waddr   (waddr),
    .wdata   (in_value),
    .raddr_a (front_addr),
    .raddr_b (rear_addr),
    .rdata_a (rd_front),
    .rdata_b (rd_rear)
  );

  // ------------------------------------------------------------- results
  // cnt_r already holds the post-command count during the result beat
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_count       = cnt_r;
  assign out_front_value = (cnt_r == '0) ? INT_MAX : (fwd_front_r ? wdata_r : rd_front);
  assign out_rear_value  = (cnt_r == '0) ? INT_MAX : (fwd_rear_r ? wdata_r : rd_rear);

  // ----------------------------------------------------------- assertions
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count exceeds ring depth");

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_strobe)
    else $error("command beat without result beat");

  a_ovf_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_OVERFLOW) |-> (out_count == $past(cnt_r)))
    else $error("overflow changed the count");

  a_udf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_UNDERFLOW) |-> (out_count == '0))
    else $error("underflow reported on a non-empty deque");

endmodule
